// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they expand to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked property, disabled while reset is asserted.
`define CNL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked property that also holds while reset is asserted.
`define CNL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CNL_ASSERT(lbl, prop, msg)
`define CNL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/cnl_pkg.sv =====
// ----------------------------------------------------------------------------
// Changed namespace list package
// Sizes, codes and shared types of the changed namespace list unit.
// ----------------------------------------------------------------------------
package cnl_pkg;

  // Number of entries the list can hold.
  localparam int CAPACITY = 1024;

  localparam int NSID_W = 32;
  localparam int POS_W  = 10;
  // Ring index and entry count widths.
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  // Common width for comparing positions, steps and counts.
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [NSID_W-1:0] BROADCAST_NSID = {NSID_W{1'b1}};
  localparam logic [IDX_W-1:0]  LAST_STEP      = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT       = CNT_W'(CAPACITY);

  // Request operation codes.
  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_READ   = 1'b1
  } cnl_op_e;

  // Control state, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_INSERT = 4'b0010,
    ST_READ   = 4'b0100,
    ST_FINISH = 4'b1000
  } cnl_state_e;

  // Per-cycle control from the sequencer to the insert merge unit.
  typedef struct packed {
    logic load;        // take a new ID to insert
    logic step;        // ring rotates this cycle
    logic rank_valid;  // the head entry is a live list entry
    logic at_count;    // the head is the first free slot
  } cnl_merge_ctl_t;

endpackage

// ===== sv/changed_namespace_list_unit.sv =====
// ----------------------------------------------------------------------------
// Changed namespace list unit
// Sorted, duplicate-free list of changed namespace IDs held in a ring of
// cells, serving the dwords of its log page.
// ----------------------------------------------------------------------------
// Appends that set or meet overflow finish without leaving idle; an insert
// rotates the ring of CAPACITY cells once before the next request is taken.
// Reads answered from overflow or past the end give their result in the
// cycle after the request; a read of a live entry rotates the ring once,
// then gives its result from ST_FINISH when the output is free.
// Reset empties the list and clears overflow; the cells are not cleared.
`include "assert_macros.svh"

module changed_namespace_list_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       op_i,
  input  logic [cnl_pkg::NSID_W-1:0] nsid_i,
  input  logic [cnl_pkg::POS_W-1:0]  dword_position_i,
  input  logic                       last_read_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       written_o,
  output logic [cnl_pkg::NSID_W-1:0] entry_value_o
);
  import cnl_pkg::*;

  cnl_state_e        state_q, state_d;
  logic [IDX_W-1:0]  step_q, step_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              overflow_q, overflow_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              last_q, last_d;
  logic [NSID_W-1:0] res_q, res_d;
  logic              out_valid_q, out_valid_d;
  logic              written_q, written_d;
  logic [NSID_W-1:0] value_q, value_d;

  logic              in_acc;
  logic              out_free;
  logic              last_step;
  logic              shift;
  logic              insert;
  logic [NSID_W-1:0] head;
  logic [NSID_W-1:0] tail;
  logic [NSID_W-1:0] cell_id [CAPACITY];
  cnl_merge_ctl_t    mctl;

  // Handshake: requests are taken only in idle with room for a result.
  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_step   = (step_q == LAST_STEP);
  assign shift       = (state_q == ST_INSERT) || (state_q == ST_READ);

  // Ring of cells: each slot takes its upper neighbor, the top takes the tail.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [NSID_W-1:0] nxt;
    if (i == CAPACITY - 1) begin : g_top
      assign nxt = tail;
    end else begin : g_mid
      assign nxt = cell_id[i+1];
    end
    cnl_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .id_i    (nxt),
      .id_o    (cell_id[i])
    );
  end

  assign head = cell_id[0];

  // Merge control: the head holds the entry of rank step_q.
  always_comb begin
    mctl.load       = in_acc && (cnl_op_e'(op_i) == OP_APPEND) && !overflow_q &&
                      (nsid_i != BROADCAST_NSID) && (count_q != FULL_CNT);
    mctl.step       = (state_q == ST_INSERT);
    mctl.rank_valid = (CNT_W'(step_q) < count_q);
    mctl.at_count   = (CNT_W'(step_q) == count_q);
  end

  cnl_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mctl),
    .nsid_i   (nsid_i),
    .head_i   (head),
    .tail_o   (tail),
    .insert_o (insert)
  );

  // Sequencer, list state and result path.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    overflow_d  = overflow_q;
    pos_d       = pos_q;
    last_d      = last_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    written_d   = written_q;
    value_d     = value_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cnl_op_e'(op_i) == OP_APPEND) begin
            if (!overflow_q) begin
              if ((nsid_i == BROADCAST_NSID) || (count_q == FULL_CNT)) begin
                overflow_d = 1'b1;
                count_d    = '0;
              end else begin
                state_d = ST_INSERT;
                step_d  = '0;
              end
            end
          end else if (overflow_q) begin
            out_valid_d = 1'b1;
            written_d   = (dword_position_i == '0);
            value_d     = (dword_position_i == '0) ? BROADCAST_NSID : '0;
            if (last_read_i) begin
              overflow_d = 1'b0;
              count_d    = '0;
            end
          end else if (CMP_W'(dword_position_i) < CMP_W'(count_q)) begin
            state_d = ST_READ;
            step_d  = '0;
            pos_d   = dword_position_i;
            last_d  = last_read_i;
          end else begin
            out_valid_d = 1'b1;
            written_d   = 1'b0;
            value_d     = '0;
            if (last_read_i) begin
              count_d = '0;
            end
          end
        end
      end
      ST_INSERT: begin
        step_d = step_q + IDX_W'(1);
        if (insert) begin
          count_d = count_q + CNT_W'(1);
        end
        if (last_step) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        step_d = step_q + IDX_W'(1);
        if (CMP_W'(step_q) == CMP_W'(pos_q)) begin
          res_d = head;
        end
        if (last_step) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          written_d   = 1'b1;
          value_d     = res_q;
          if (last_q) begin
            count_d    = '0;
            overflow_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      overflow_q  <= overflow_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    last_q    <= last_d;
    res_q     <= res_d;
    written_q <= written_d;
    value_q   <= value_d;
  end

  assign out_valid_o   = out_valid_q;
  assign written_o     = written_q;
  assign entry_value_o = value_q;

  // Checks on list bookkeeping and sequencing.
  `CNL_ASSERT(a_count_bound, count_q <= FULL_CNT, "entry count above capacity")
  `CNL_ASSERT(a_overflow_empty, overflow_q |-> (count_q == '0),
              "list not empty during overflow")
  `CNL_ASSERT(a_insert_ends, (state_q == ST_INSERT) && last_step |=> (state_q == ST_IDLE),
              "insert did not end after one rotation")
  `CNL_ASSERT(a_insert_grow, (state_q == ST_INSERT) |=>
              (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)),
              "insert grew the list by more than one")
  `CNL_ASSERT(a_read_no_ovf, (state_q == ST_READ) |-> !overflow_q,
              "ring read during overflow")

endmodule

// ===== sv/cnl_cell.sv =====
// ----------------------------------------------------------------------------
// Changed namespace list cell
// One ring slot: holds one namespace ID and takes its neighbor's on a shift.
// ----------------------------------------------------------------------------
module cnl_cell (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  logic [cnl_pkg::NSID_W-1:0] id_i,
  output logic [cnl_pkg::NSID_W-1:0] id_o
);
  import cnl_pkg::*;

  logic [NSID_W-1:0] id_q;

  // Slot contents move one place toward the head when the ring rotates.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      id_q <= id_i;
    end
  end

  assign id_o = id_q;

endmodule

// ===== sv/cnl_merge.sv =====
// ----------------------------------------------------------------------------
// Changed namespace list insert merge
// Sits where the ring closes and merges one new ID into the sorted stream.
// ----------------------------------------------------------------------------
module cnl_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cnl_pkg::cnl_merge_ctl_t    ctl_i,
  input  logic [cnl_pkg::NSID_W-1:0] nsid_i,
  input  logic [cnl_pkg::NSID_W-1:0] head_i,
  output logic [cnl_pkg::NSID_W-1:0] tail_o,
  output logic                       insert_o
);
  import cnl_pkg::*;

  logic              active_q, active_d;
  logic [NSID_W-1:0] pend_q, pend_d;

  // The pending ID swaps with any larger entry passing by, so the largest
  // value is carried on and dropped into the first free slot. An equal
  // entry cancels the insert.
  always_comb begin
    tail_o   = head_i;
    active_d = active_q;
    pend_d   = pend_q;
    insert_o = 1'b0;
    if (ctl_i.load) begin
      active_d = 1'b1;
      pend_d   = nsid_i;
    end else if (ctl_i.step && active_q) begin
      if (ctl_i.rank_valid) begin
        if (pend_q < head_i) begin
          tail_o = pend_q;
          pend_d = head_i;
        end else if (pend_q == head_i) begin
          active_d = 1'b0;
        end
      end else if (ctl_i.at_count) begin
        tail_o   = pend_q;
        active_d = 1'b0;
        insert_o = 1'b1;
      end
    end
  end

  // Insert-in-progress flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  // Pending ID.
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Changed namespace list unit testbench
// Drives appends and log page reads with random idle cycles on both sides and
// checks every returned dword against a sorted-list predictor: a short
// directed part, then random append and page read sequences with overflow
// events, then a few closing reads.
// ----------------------------------------------------------------------------
module tb_top;
  import cnl_pkg::*;

  // Number of counted requests in the random part.
  localparam int unsigned RANDOM_REQS = 530;
  // Length of the long receiver hold-off, in cycles.
  localparam int unsigned LONG_HOLD   = 3000;

  // Predictor and store of expected log page dwords.
  class nsid_list_scoreboard;
    typedef struct {
      logic              written;
      logic [NSID_W-1:0] value;
    } page_dword_t;

    logic [NSID_W-1:0] ids[$];
    bit                overflowed;
    page_dword_t       page_dwords[$];
    int unsigned       errors;
    int unsigned       appends;
    int unsigned       reads;
    int unsigned       results;
    int unsigned       overflows;

    // Applies one accepted request to the predicted list.
    function void note_request(cnl_op_e op, logic [NSID_W-1:0] nsid,
                               logic [POS_W-1:0] pos, logic last);
      page_dword_t d;
      int unsigned slot;
      if (op == OP_APPEND) begin
        appends++;
        if (nsid == BROADCAST_NSID || ids.size() >= CAPACITY) begin
          if (!overflowed) overflows++;
          overflowed = 1'b1;
          ids.delete();
        end
        if (!overflowed) begin
          slot = 0;
          while (slot < ids.size() && ids[slot] < nsid) slot++;
          if (slot == ids.size() || ids[slot] != nsid) ids.insert(slot, nsid);
        end
      end else begin
        reads++;
        if (overflowed) begin
          d.written = (pos == '0);
          d.value   = (pos == '0) ? BROADCAST_NSID : '0;
        end else if (pos < ids.size()) begin
          d.written = 1'b1;
          d.value   = ids[pos];
        end else begin
          d.written = 1'b0;
          d.value   = '0;
        end
        page_dwords.push_back(d);
        if (last) begin
          ids.delete();
          overflowed = 1'b0;
        end
      end
    endfunction

    // Compares one accepted result with the oldest expected dword.
    function void check_result(logic written, logic [NSID_W-1:0] value);
      page_dword_t d;
      results++;
      if (page_dwords.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual written %0b value %h",
                 $time, written, value);
      end else begin
        d = page_dwords.pop_front();
        if (written !== d.written) begin
          errors++;
          $display("%0t: written mismatch, expected %0b, actual %0b",
                   $time, d.written, written);
        end
        if (value !== d.value) begin
          errors++;
          $display("%0t: entry_value mismatch, expected %h, actual %h",
                   $time, d.value, value);
        end
      end
    endfunction

    function int unsigned pending();
      return page_dwords.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic              op_i             = OP_APPEND;
  logic [NSID_W-1:0] nsid_i           = '0;
  logic [POS_W-1:0]  dword_position_i = '0;
  logic              last_read_i      = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic              written_o;
  logic [NSID_W-1:0] entry_value_o;

  nsid_list_scoreboard sb = new();

  bit          calm         = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned counted      = 0;

  changed_namespace_list_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .nsid_i           (nsid_i),
    .dword_position_i (dword_position_i),
    .last_read_i      (last_read_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .written_o        (written_o),
    .entry_value_o    (entry_value_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run.
  initial begin
    #(100_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Both handshakes are observed at the rising edge; results before requests.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(written_o, entry_value_o);
      if (in_valid_i && !in_stall_o) begin
        sb.note_request(cnl_op_e'(op_i), nsid_i, dword_position_i, last_read_i);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin : result_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
        out_stall_i  <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 11);
      end
    end
  end

  // Offers one request after random idle cycles and waits until it is taken.
  task automatic issue(cnl_op_e op, logic [NSID_W-1:0] nsid,
                       logic [POS_W-1:0] pos, logic last);
    bit ignored;
    ignored = (op == OP_APPEND) && sb.overflowed;
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    nsid_i           <= nsid;
    dword_position_i <= pos;
    last_read_i      <= last;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
    if (!ignored) counted++;
  endtask

  // Stops offering requests until every expected dword has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Namespace ID mix: small values for duplicates, full range and extremes.
  function automatic logic [NSID_W-1:0] pick_nsid();
    int unsigned dice;
    dice = $urandom_range(0, 99);
    if (dice < 40) return NSID_W'($urandom_range(0, 15));
    if (dice < 80) begin
      pick_nsid = $urandom;
      if (pick_nsid == BROADCAST_NSID) pick_nsid = '0;
      return pick_nsid;
    end
    if (dice < 90) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return NSID_W'(1);
        2:       return BROADCAST_NSID - 1;
        default: return {1'b1, {(NSID_W-1){1'b0}}};
      endcase
    end
    return BROADCAST_NSID - NSID_W'($urandom_range(1, 8));
  endfunction

  // Reads the log page from position 0, sometimes one past the end.
  task automatic read_page();
    int unsigned span;
    bit          finish_page;
    span        = sb.overflowed ? 2 : sb.ids.size() + $urandom_range(0, 1);
    finish_page = ($urandom_range(0, 99) < 80);
    if (span == 0) span = 1;
    for (int unsigned p = 0; p < span; p++) begin
      issue(OP_READ, $urandom, POS_W'(p), finish_page && (p == span - 1));
    end
  endtask

  // Main stimulus.
  initial begin : stimulus
    int unsigned      dice;
    bit               hold_done;
    bit               paused;
    hold_done = 1'b0;
    paused    = 1'b0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: empty reads, sorted inserts, duplicates, overflow.
    issue(OP_READ,   '0, '0, 1'b0);
    issue(OP_APPEND, '0, '0, 1'b0);
    issue(OP_APPEND, {1'b1, {(NSID_W-1){1'b0}}}, '1, 1'b1);
    issue(OP_APPEND, {1'b1, {(NSID_W-1){1'b0}}}, '0, 1'b0);
    issue(OP_APPEND, BROADCAST_NSID - 1, '0, 1'b0);
    issue(OP_APPEND, NSID_W'(5), '0, 1'b0);
    for (int unsigned p = 0; p < 5; p++) issue(OP_READ, BROADCAST_NSID, POS_W'(p), 1'b0);
    issue(OP_READ,   '0, '1, 1'b0);
    issue(OP_READ,   '0, POS_W'(3), 1'b1);
    issue(OP_READ,   '0, '0, 1'b0);
    issue(OP_APPEND, NSID_W'(7), '0, 1'b0);
    issue(OP_APPEND, BROADCAST_NSID, '0, 1'b0);
    issue(OP_APPEND, NSID_W'(9), '0, 1'b0);
    issue(OP_APPEND, BROADCAST_NSID, '0, 1'b0);
    issue(OP_READ,   '0, '0, 1'b0);
    issue(OP_READ,   '0, '1, 1'b0);
    issue(OP_READ,   '0, '0, 1'b1);
    issue(OP_READ,   '0, '0, 1'b0);
    issue(OP_APPEND, BROADCAST_NSID, '0, 1'b0);
    issue(OP_READ,   '0, POS_W'(5), 1'b1);
    issue(OP_APPEND, NSID_W'(3), '1, 1'b1);
    issue(OP_READ,   '0, '0, 1'b1);
    drain_results();

    // Random part: mostly appends followed by a page read.
    counted = 0;
    while (counted < RANDOM_REQS) begin
      calm = (counted >= 150 && counted < 260);
      if (!hold_done && counted >= 60) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (!paused && counted >= 300) begin
        drain_results();
        paused = 1'b1;
      end
      dice = $urandom_range(0, 99);
      if (dice < 70) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 99) < 4) begin
            issue(OP_APPEND, BROADCAST_NSID, POS_W'($urandom), 1'($urandom));
          end else begin
            issue(OP_APPEND, pick_nsid(), POS_W'($urandom), 1'($urandom));
          end
        end
        read_page();
      end else if (dice < 78) begin
        issue(OP_APPEND, BROADCAST_NSID, POS_W'($urandom), 1'($urandom));
      end else if (dice < 92) begin
        issue(OP_READ, $urandom, POS_W'($urandom_range(0, 7)),
              $urandom_range(0, 3) == 0);
      end else begin
        issue(OP_READ, $urandom, POS_W'($urandom), 1'b0);
      end
    end
    calm = 1'b0;
    drain_results();

    // Closing reads around one more append.
    issue(OP_READ,   $urandom, '0, 1'b0);
    issue(OP_READ,   $urandom, '1, 1'b0);
    issue(OP_APPEND, NSID_W'(3), '0, 1'b0);
    issue(OP_READ,   $urandom, '0, 1'b1);
    in_valid_i <= 1'b0;

    // Let outstanding work finish, then report.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (CAPACITY + 16) @(posedge clk_i);
    $display("Run covered %0d appends and %0d log page reads, %0d dwords checked,",
             sb.appends, sb.reads, sb.results);
    $display("with %0d overflow events along the way.", sb.overflows);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
